/* hdl/sarl_pkg.sv */
// Shared types, constants and codes of the source address rate limiter.
`timescale 1ns / 1ps
`default_nettype none
package sarl_pkg;
	localparam int unsigned TABLE_ENTRIES = 64;
	localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
	localparam int unsigned TIME_W = 48;
	localparam int unsigned CNT_W = 16;
	localparam int unsigned CFG_W = 24;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [7:0] KIND_DATABLOCK = 8'd78;
	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	localparam logic [2:0] V_BYPASS = 3'd0;
	localparam logic [2:0] V_PASS = 3'd1;
	localparam logic [2:0] V_BANNED = 3'd2;
	localparam logic [2:0] V_LIMIT = 3'd3;
	localparam logic [2:0] V_FULL = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_DATABLOCK = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BAN = 2'd3;

	// Classified packet handed from the front part to the back part
	typedef struct packed {
		logic             bypass;
		logic [63:0]      addr_high;
		logic [63:0]      addr_low;
		logic [TIME_W-1:0] now;
	} item_t;

	// Register settings used by the back part
	typedef struct packed {
		logic [CNT_W-1:0] query_limit;
		logic [15:0]      window_ms;
		logic [23:0]      ban_ms;
	} cfg_t;
endpackage
`default_nettype wire

/* hdl/sarl_front.sv */
// Front part: classify packets and queue them for the table engine.
`timescale 1ns / 1ps
`default_nettype none
module sarl_front import sarl_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [63:0] src_addr_high,
	input  wire logic [63:0] src_addr_low,
	input  wire logic        addr_is_ip,
	input  wire logic [7:0]  packet_kind,
	input  wire logic [TIME_W-1:0] now_ms,
	input  wire logic        datablock_enabled,
	output logic             item_valid,
	output item_t            item,
	input  wire logic        item_take
);
	// two-entry queue
	item_t  buf_q [2];
	logic   wr_q, rd_q;
	logic [1:0] cnt_q;
	item_t  in_item;

	assign full = (cnt_q == 2'd2);
	assign item_valid = (cnt_q != 2'd0);
	assign item = buf_q[rd_q];

	// classify the incoming beat
	always_comb begin
		in_item.bypass = !addr_is_ip || (datablock_enabled && packet_kind == KIND_DATABLOCK);
		in_item.addr_high = src_addr_high;
		in_item.addr_low = src_addr_low;
		in_item.now = now_ms;
	end

	always_ff @(posedge clk) begin
		if (push && !full) begin
			buf_q[wr_q] <= in_item;
		end
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push && !full) wr_q <= !wr_q;
			if (item_take && item_valid) rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'((push && !full) ? 1 : 0) - 2'((item_take && item_valid) ? 1 : 0);
		end
	end
endmodule
`default_nettype wire

/* hdl/sarl_back.sv */
// Back part: table match, window and ban update, result register.
`timescale 1ns / 1ps
`default_nettype none
module sarl_back import sarl_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  item_valid,
	input  wire item_t item,
	output logic       item_take,
	input  wire cfg_t  cfg,
	output logic       res_valid,
	output logic [2:0] res_verdict,
	input  wire logic  res_take
);
	localparam logic ST_MATCH = 1'b0;
	localparam logic ST_UPDATE = 1'b1;

	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [63:0] hi_q [TABLE_ENTRIES];
	logic [63:0] lo_q [TABLE_ENTRIES];
	logic [TIME_W-1:0] ws_mem [TABLE_ENTRIES];
	logic [TIME_W-1:0] be_mem [TABLE_ENTRIES];
	logic [CNT_W-1:0] wc_mem [TABLE_ENTRIES];

	logic state_q;
	item_t cur_q;
	logic [IDX_W-1:0] slot_q;
	logic new_q;
	logic [TIME_W-1:0] ws_q, be_q;
	logic [CNT_W-1:0] wc_q;

	logic [TABLE_ENTRIES-1:0] hit;
	logic hit_any, free_any;
	logic [IDX_W-1:0] hit_idx, free_idx;

	// parallel address match and lowest free entry
	always_comb begin
		hit_any = 1'b0;
		free_any = 1'b0;
		hit_idx = '0;
		free_idx = '0;
		for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
			hit[i] = valid_q[i] && hi_q[i] == item.addr_high && lo_q[i] == item.addr_low;
			if (hit[i]) begin
				hit_any = 1'b1;
				hit_idx = IDX_W'(i);
			end
			if (!valid_q[i]) begin
				free_any = 1'b1;
				free_idx = IDX_W'(i);
			end
		end
	end

	logic out_free;
	assign out_free = !res_valid || res_take;
	logic go_match;
	assign go_match = state_q == ST_MATCH && item_valid && out_free;
	assign item_take = go_match;

	// update arithmetic on the fetched entry
	logic [TIME_W-1:0] ws_e, be_e, ws_n, be_n;
	logic [CNT_W-1:0] wc_e, wc_n;
	logic [TIME_W:0] end_sum;
	logic banned, restart, hit_lim;
	logic [2:0] upd_verdict;
	always_comb begin
		ws_e = new_q ? '0 : ws_q;
		be_e = new_q ? '0 : be_q;
		wc_e = new_q ? '0 : wc_q;
		banned = cur_q.now < be_e;
		restart = (cur_q.now - ws_e) >= TIME_W'(cfg.window_ms);
		ws_n = restart ? cur_q.now : ws_e;
		wc_n = restart ? '0 : wc_e;
		if (wc_n != CNT_MAX) wc_n = wc_n + 1'b1;
		hit_lim = wc_n >= cfg.query_limit;
		end_sum = {1'b0, cur_q.now} + (TIME_W+1)'(cfg.ban_ms);
		be_n = end_sum[TIME_W] ? TIME_MAX : end_sum[TIME_W-1:0];
		if (!hit_lim) be_n = be_e;
		if (banned) upd_verdict = V_BANNED;
		else if (hit_lim) upd_verdict = V_LIMIT;
		else upd_verdict = V_PASS;
	end

	// entry read and write
	always_ff @(posedge clk) begin
		if (go_match) begin
			cur_q <= item;
			slot_q <= hit_any ? hit_idx : free_idx;
			new_q <= !hit_any;
			ws_q <= ws_mem[hit_idx];
			be_q <= be_mem[hit_idx];
			wc_q <= wc_mem[hit_idx];
			if (!item.bypass && !hit_any && free_any) begin
				hi_q[free_idx] <= item.addr_high;
				lo_q[free_idx] <= item.addr_low;
			end
		end
		if (state_q == ST_UPDATE) begin
			if (!banned) begin
				ws_mem[slot_q] <= ws_n;
				wc_mem[slot_q] <= wc_n;
				be_mem[slot_q] <= be_n;
			end else if (new_q) begin
				ws_mem[slot_q] <= ws_e;
				wc_mem[slot_q] <= wc_e;
				be_mem[slot_q] <= be_e;
			end
		end
	end

	// a result beat is loaded on a finished update or a bypass / table-full match
	logic res_set;
	assign res_set = state_q == ST_UPDATE ||
		(go_match && (item.bypass || (!hit_any && !free_any)));

	// sequencer, valid bits and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_MATCH;
			valid_q <= '0;
			res_valid <= 1'b0;
			res_verdict <= V_BYPASS;
		end else begin
			if (res_set) res_valid <= 1'b1;
			else if (res_take) res_valid <= 1'b0;
			unique case (state_q)
				ST_MATCH: begin
					if (go_match) begin
						if (item.bypass) begin
							res_verdict <= V_BYPASS;
						end else if (!hit_any && !free_any) begin
							res_verdict <= V_FULL;
						end else begin
							if (!hit_any) valid_q[free_idx] <= 1'b1;
							state_q <= ST_UPDATE;
						end
					end
				end
				ST_UPDATE: begin
					res_verdict <= upd_verdict;
					state_q <= ST_MATCH;
				end
				default: state_q <= ST_MATCH;
			endcase
		end
	end
endmodule
`default_nettype wire

/* hdl/source_address_rate_limiter_unit.sv */
// Top level of the source address rate limiter.
// A bypass or table-full beat is loaded into the result register when it is matched;
// a tracked beat first passes the match state and then the entry update state, which
// comes from the single read-modify-write of one table entry. No new beat is matched
// during the update state, nor while the result register is full and not popped.
// Reset: asynchronous, clears queues, table valid bits and loads register defaults.
`timescale 1ns / 1ps
`default_nettype none
module source_address_rate_limiter_unit import sarl_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [63:0] src_addr_high,
	input  wire logic [63:0] src_addr_low,
	input  wire logic        addr_is_ip,
	input  wire logic [7:0]  packet_kind,
	input  wire logic [TIME_W-1:0] now_ms,
	output logic             empty,
	input  wire logic        pop,
	output logic             accept,
	output logic [2:0]       verdict,
	input  wire logic        cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data
);
	logic datablock_q;
	cfg_t cfg_q;
	logic item_valid, item_take, res_valid;
	item_t item;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			datablock_q <= 1'b0;
			cfg_q.query_limit <= 16'd15;
			cfg_q.window_ms <= 16'd1000;
			cfg_q.ban_ms <= 24'd60000;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DATABLOCK: datablock_q <= cfg_data[0];
				REG_LIMIT: cfg_q.query_limit <= cfg_data[15:0];
				REG_WINDOW: cfg_q.window_ms <= cfg_data[15:0];
				REG_BAN: cfg_q.ban_ms <= cfg_data;
				default: ;
			endcase
		end
	end

	sarl_front u_front (
		.clk, .arst_n, .push, .full, .src_addr_high, .src_addr_low, .addr_is_ip,
		.packet_kind, .now_ms, .datablock_enabled(datablock_q),
		.item_valid, .item, .item_take
	);

	sarl_back u_back (
		.clk, .arst_n, .item_valid, .item, .item_take, .cfg(cfg_q),
		.res_valid, .res_verdict(verdict), .res_take(pop)
	);

	assign empty = !res_valid;
	assign accept = !(verdict == V_BANNED || verdict == V_LIMIT);
endmodule
`default_nettype wire

/* tb/sv/tb_source_address_rate_limiter_unit.sv */
// Testbench for the source address rate limiter: queue-driven stimulus checked against a predictor.
`timescale 1ns / 1ps
`default_nettype none
module tb_source_address_rate_limiter_unit;
	import sarl_pkg::*;

	// Tracks the policing table and the verdicts still owed by the block
	class verdict_scoreboard;
		bit              db_on;
		bit [15:0]       limit;
		bit [15:0]       win;
		bit [23:0]       ban;
		bit              used [TABLE_ENTRIES];
		bit [63:0]       hi_tab [TABLE_ENTRIES];
		bit [63:0]       lo_tab [TABLE_ENTRIES];
		bit [47:0]       start_tab [TABLE_ENTRIES];
		bit [47:0]       ban_tab [TABLE_ENTRIES];
		bit [15:0]       cnt_tab [TABLE_ENTRIES];
		logic [2:0]      owed [$];
		int              errors;

		function void clear();
			db_on = 0;
			limit = 15;
			win = 1000;
			ban = 60000;
			foreach (used[i]) used[i] = 0;
			owed.delete();
			errors = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
			case (idx)
				REG_DATABLOCK: db_on = val[0];
				REG_LIMIT: limit = val[15:0];
				REG_WINDOW: win = val[15:0];
				REG_BAN: ban = val;
			endcase
		endfunction

		// Work out the verdict of one accepted beat and update the table
		function void note_beat(bit [63:0] hi, bit [63:0] lo, bit ip, bit [7:0] kind,
				bit [47:0] now);
			int slot;
			int spare;
			bit [48:0] stop;
			slot = -1;
			spare = -1;
			if (!ip || (db_on && kind == KIND_DATABLOCK)) begin
				owed.push_back(V_BYPASS);
				return;
			end
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				if (used[i]) begin
					if (slot < 0 && hi_tab[i] == hi && lo_tab[i] == lo) slot = i;
				end else if (spare < 0) begin
					spare = i;
				end
			end
			if (slot < 0) begin
				if (spare < 0) begin
					owed.push_back(V_FULL);
					return;
				end
				slot = spare;
				used[slot] = 1;
				hi_tab[slot] = hi;
				lo_tab[slot] = lo;
				start_tab[slot] = 0;
				ban_tab[slot] = 0;
				cnt_tab[slot] = 0;
			end
			if (now < ban_tab[slot]) begin
				owed.push_back(V_BANNED);
				return;
			end
			if (48'(now - start_tab[slot]) >= win) begin
				start_tab[slot] = now;
				cnt_tab[slot] = 0;
			end
			if (cnt_tab[slot] != CNT_MAX) cnt_tab[slot]++;
			if (cnt_tab[slot] >= limit) begin
				stop = {1'b0, now} + ban;
				ban_tab[slot] = stop[48] ? TIME_MAX : stop[47:0];
				owed.push_back(V_LIMIT);
				return;
			end
			owed.push_back(V_PASS);
		endfunction

		function void check_beat(logic acc, logic [2:0] got);
			logic [2:0] want;
			if (owed.size() == 0) begin
				$error("result beat with nothing expected: verdict %0d", got);
				errors++;
				return;
			end
			want = owed.pop_front();
			if (got !== want) begin
				$error("verdict: expected %0d, actual %0d", want, got);
				errors++;
			end
			if (acc !== !(want == V_BANNED || want == V_LIMIT)) begin
				$error("accept: expected %0d, actual %0d",
					!(want == V_BANNED || want == V_LIMIT), acc);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic push = 0;
	logic full;
	logic [63:0] src_addr_high = 0;
	logic [63:0] src_addr_low = 0;
	logic addr_is_ip = 0;
	logic [7:0] packet_kind = 0;
	logic [TIME_W-1:0] now_ms = 0;
	logic empty;
	logic pop = 0;
	logic accept;
	logic [2:0] verdict;
	logic cfg_we = 0;
	logic [CFG_IDX_W-1:0] cfg_index = 0;
	logic [CFG_W-1:0] cfg_data = 0;

	verdict_scoreboard sb = new();
	bit [63:0] pool_hi [48];
	bit [63:0] pool_lo [48];
	bit [47:0] clock_ms = 0;
	bit stall_heavy = 0;

	source_address_rate_limiter_unit dut (.*);

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	// Note accepted inputs and check accepted results
	always @(posedge clk) begin
		if (arst_n && push && !full)
			sb.note_beat(src_addr_high, src_addr_low, addr_is_ip, packet_kind, now_ms);
		if (arst_n && pop && !empty)
			sb.check_beat(accept, verdict);
	end

	// Receiver: swap between light and heavy stalling at random
	always @(negedge clk) begin
		if ($urandom_range(0, 47) == 0) stall_heavy = !stall_heavy;
		pop <= stall_heavy ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 7) != 0);
	end

	// Present one beat and hold it until the block takes it
	task automatic send_beat(bit [63:0] hi, bit [63:0] lo, bit ip, bit [7:0] kind,
			bit [47:0] now);
		src_addr_high = hi;
		src_addr_low = lo;
		addr_is_ip = ip;
		packet_kind = kind;
		now_ms = now;
		push = 1;
		do @(posedge clk); while (full);
		@(negedge clk);
	endtask

	task automatic pause_beats(int cycles);
		push = 0;
		repeat (cycles) @(negedge clk);
	endtask

	// Drain, then write one register
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		push = 0;
		while (sb.owed.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		cfg_we = 1;
		cfg_index = idx;
		cfg_data = val;
		@(posedge clk);
		sb.write_reg(idx, val);
		@(negedge clk);
		cfg_we = 0;
	endtask

	task automatic set_all(bit db, bit [15:0] lim, bit [15:0] w, bit [23:0] b);
		write_reg(REG_DATABLOCK, db);
		write_reg(REG_LIMIT, lim);
		write_reg(REG_WINDOW, w);
		write_reg(REG_BAN, b);
	endtask

	// Random traffic: mostly known sources unless fresh is set, bursts of beats with gaps
	task automatic random_beats(int count, bit fresh);
		int left;
		int k;
		bit [63:0] hi;
		bit [63:0] lo;
		left = 0;
		repeat (count) begin
			if (left == 0) begin
				pause_beats($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6));
				left = $urandom_range(1, 20);
			end
			left--;
			k = $urandom_range(0, 47);
			hi = pool_hi[k];
			lo = pool_lo[k];
			if (fresh || $urandom_range(0, 19) == 0) begin
				hi = {$urandom, $urandom};
				lo = {$urandom, $urandom};
			end
			if ($urandom_range(0, 49) == 0)
				clock_ms = {$urandom, $urandom};
			else
				clock_ms += $urandom_range(0, 40);
			send_beat(hi, lo, $urandom_range(0, 9) != 0,
				$urandom_range(0, 2) == 0 ? KIND_DATABLOCK : 8'($urandom), clock_ms);
		end
	endtask

	initial begin
		sb.clear();
		foreach (pool_hi[i]) begin
			pool_hi[i] = {$urandom, $urandom};
			pool_lo[i] = {$urandom, $urandom};
		end
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Reset settings: non-IP, datablock kind not filtered, run one source to its ban
		send_beat('1, '1, 0, KIND_DATABLOCK, 0);
		send_beat(0, 0, 1, KIND_DATABLOCK, 5);
		repeat (16) send_beat('1, '1, 1, 8'hff, 10);
		send_beat('1, '1, 1, 0, 60009);
		send_beat('1, '1, 1, 0, 60010);
		send_beat(0, 0, 1, 0, 2000);

		// Datablock bypass, zero limit, saturating ban end, time going back
		set_all(1, 0, 1, 24'hffffff);
		send_beat(0, 1, 1, KIND_DATABLOCK, 100);
		send_beat(0, 1, 1, 8'h4f, TIME_MAX - 5);
		send_beat(0, 1, 1, 8'h4f, TIME_MAX);
		send_beat(0, 0, 1, 8'h00, 3);
		send_beat(0, 0, 1, 8'h00, 3);

		// Zero window and zero ban
		set_all(0, 2, 0, 0);
		send_beat(1, 0, 1, 8'h10, 50);
		send_beat(1, 0, 1, KIND_DATABLOCK, 50);
		send_beat(1, 0, 1, 8'h10, 50);

		set_all(1, 4, 50, 200);
		random_beats(180, 0);
		set_all(0, 0, 1, 0);
		random_beats(150, 0);
		set_all(1, 16'hffff, 16'hffff, 24'hffffff);
		random_beats(150, 0);
		set_all(0, 3, 0, 100);
		random_beats(150, 0);
		set_all(1, 8, 1000, 60000);
		random_beats(120, 0);
		// Fresh sources run the table out of room
		random_beats(120, 1);

		push = 0;
		while (sb.owed.size() != 0) @(negedge clk);
		repeat (10) @(negedge clk);
		if (sb.errors == 0)
			$display("PASS source_address_rate_limiter_unit");
		else
			$display("FAIL source_address_rate_limiter_unit");
		$finish;
	end

	// Guard against a hung handshake
	initial begin
		#5_000_000;
		$display("FAIL source_address_rate_limiter_unit");
		$finish;
	end
endmodule
`default_nettype wire
